// ===== hdl/weighted_focal_window_filter_defines.svh =====
// Assertion shorthands shared by the filter RTL.
// Each expects clk and rst_n in scope.
`ifndef WEIGHTED_FOCAL_WINDOW_FILTER_DEFINES_SVH
`define WEIGHTED_FOCAL_WINDOW_FILTER_DEFINES_SVH

// Same-cycle implication.
`define WFWF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WFWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wfwf_pkg.sv =====
`timescale 1ns / 1ps

package wfwf_pkg;

    // Store geometry
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int MAX_HALF  = 3;
    localparam int WIN_SPAN  = 2 * MAX_HALF + 1;
    localparam int WIN_CELLS = WIN_SPAN * WIN_SPAN;
    localparam int PIX_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int WT_AW     = $clog2(WIN_CELLS);
    localparam int SPAN_W    = $clog2(WIN_SPAN);

    // Field widths
    localparam int ACT_W  = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int VAL_W  = 16;
    localparam int RES_W  = 38;
    localparam int CNT_W  = 6;
    localparam int DIM_W  = 7;
    localparam int HALF_W = 2;
    localparam int POS_W  = ROW_W + 2;
    localparam int PROD_W = 2 * VAL_W;

    // Actions
    localparam logic [ACT_W-1:0] ACT_PIXEL   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WEIGHT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_COLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_MODE  = 3'd4;

    // Divider control and status
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/wfwf_in_if.sv =====
`timescale 1ns / 1ps

interface wfwf_in_if
    import wfwf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, action, row, col, value, input ready);
    modport sink   (input valid, action, row, col, value, output ready);
endinterface

// ===== hdl/wfwf_out_if.sv =====
`timescale 1ns / 1ps

interface wfwf_out_if
    import wfwf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result;
    logic [CNT_W-1:0]        cell_count;
    logic                    bad_request;

    modport source (output valid, result, cell_count, bad_request, input ready);
    modport sink   (input valid, result, cell_count, bad_request, output ready);
endinterface

// ===== hdl/wfwf_cfg_if.sv =====
`timescale 1ns / 1ps

interface wfwf_cfg_if
    import wfwf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/weighted_focal_window_filter.sv =====
`timescale 1ns / 1ps
`include "weighted_focal_window_filter_defines.svh"

// Weighted focal window filter. Input words either store a pixel (action
// 0), store a window weight in Q1.14 (action 1) or request one filtered
// output cell (action 2); action 3 is dropped. Pixel and weight writes
// return nothing. A compute request walks the whole (2*half_rows+1) x
// (2*half_cols+1) window, one cell per cycle through the single 16x16
// multiplier, skips cells outside the image, and returns the exact Q23.14
// sum, or in mean mode that sum divided by the in-bounds cell count
// (truncated toward zero) by a serial divider giving one quotient bit per
// cycle. The window holds 9 cells at reset and 49 at most; after the walk
// the multiply pipeline drains, mean mode then runs the divider, and the
// result is loaded into the output register. A request outside the image
// skips the walk and answers with bad_request set. The input stays not
// ready while a compute is in flight; the output register lets a new word
// enter while the last result waits. Pixel and weight stores are undefined
// until written. Configuration writes are always ready and must be issued
// only while the block is idle.
module weighted_focal_window_filter
    import wfwf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wfwf_in_if.sink    req,
    wfwf_out_if.source rsp,
    wfwf_cfg_if.sink   cfg
);
    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Configuration
    logic [DIM_W-1:0]  image_rows_reg;
    logic [DIM_W-1:0]  image_cols_reg;
    logic [HALF_W-1:0] half_rows_reg;
    logic [HALF_W-1:0] half_cols_reg;
    logic              mean_mode_reg;

    // Window walk and accumulate pipeline
    logic signed [POS_W-1:0]  base_r_reg;
    logic signed [POS_W-1:0]  base_c_reg;
    logic [SPAN_W-1:0]        wr_reg;
    logic [SPAN_W-1:0]        wc_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RES_W-1:0]  acc_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     bad_reg;

    // Output register
    logic                    out_valid_reg;
    logic signed [RES_W-1:0] out_result_reg;
    logic [CNT_W-1:0]        out_count_reg;
    logic                    out_bad_reg;

    logic [DIM_W-1:0]        nr;
    logic [DIM_W-1:0]        nc;
    logic [HALF_W-1:0]       hr;
    logic [HALF_W-1:0]       hc;
    logic [SPAN_W-1:0]       win_r_last;
    logic [SPAN_W-1:0]       win_c_last;
    logic                    accept;
    logic                    is_compute;
    logic                    is_bad;
    logic signed [POS_W-1:0] pr;
    logic signed [POS_W-1:0] pc;
    logic                    inb;
    logic                    v0;
    logic                    walk_last;
    logic                    drain_empty;
    logic                    out_load;

    logic [PIX_AW-1:0]       pix_waddr;
    logic [PIX_AW-1:0]       pix_raddr;
    logic                    pix_we;
    logic [VAL_W-1:0]        pix_rd;
    logic [WT_AW-1:0]        wt_waddr;
    logic [WT_AW-1:0]        wt_raddr;
    logic                    wt_we;
    logic [VAL_W-1:0]        wt_rd;

    div_ctl_t                div_ctl;
    div_stat_t               div_stat;
    logic signed [RES_W-1:0] div_quo;

    // Saturate oversized geometry
    assign nr = (image_rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : image_rows_reg;
    assign nc = (image_cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : image_cols_reg;
    assign hr = (half_rows_reg > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_rows_reg;
    assign hc = (half_cols_reg > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_cols_reg;

    assign win_r_last = SPAN_W'({hr, 1'b0});
    assign win_c_last = SPAN_W'({hc, 1'b0});

    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign is_compute = (req.action == ACT_COMPUTE);
    assign is_bad     = (DIM_W'(req.row) >= nr) || (DIM_W'(req.col) >= nc);

    // Store writes
    assign pix_we    = accept && (req.action == ACT_PIXEL)
                       && (int'(req.row) < MAX_ROWS) && (int'(req.col) < MAX_COLS);
    assign pix_waddr = PIX_AW'(int'(req.row) * MAX_COLS + int'(req.col));
    assign wt_we     = accept && (req.action == ACT_WEIGHT)
                       && (int'(req.row) < WIN_SPAN) && (int'(req.col) < WIN_SPAN);
    assign wt_waddr  = WT_AW'(int'(req.row) * WIN_SPAN + int'(req.col));

    // Image position of the current window cell and its bounds check
    assign pr  = base_r_reg + $signed(POS_W'(wr_reg));
    assign pc  = base_c_reg + $signed(POS_W'(wc_reg));
    assign inb = !pr[POS_W-1] && (pr < $signed(POS_W'(nr)))
                 && !pc[POS_W-1] && (pc < $signed(POS_W'(nc)));
    assign v0  = (state_reg == ST_WALK) && inb;

    assign pix_raddr = PIX_AW'(int'(pr[ROW_W-1:0]) * MAX_COLS + int'(pc[COL_W-1:0]));
    assign wt_raddr  = WT_AW'(int'(wr_reg) * WIN_SPAN + int'(wc_reg));

    assign walk_last   = (wr_reg == win_r_last) && (wc_reg == win_c_last);
    assign drain_empty = !v1_reg && !v2_reg;
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    assign div_ctl.start = (state_reg == ST_DRAIN) && drain_empty && mean_mode_reg;

    wfwf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (PIX_DEPTH)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (req.value),
        .raddr (pix_raddr),
        .rdata (pix_rd)
    );

    wfwf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WIN_CELLS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (req.value),
        .raddr (wt_raddr),
        .rdata (wt_rd)
    );

    wfwf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (acc_reg),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_compute)
                begin
                    state_next = is_bad ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_empty)
                begin
                    state_next = mean_mode_reg ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            image_rows_reg <= DIM_W'(64);
            image_cols_reg <= DIM_W'(64);
            half_rows_reg  <= HALF_W'(1);
            half_cols_reg  <= HALF_W'(1);
            mean_mode_reg  <= 1'b1;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= v0;
            v2_reg    <= v1_reg;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_IMAGE_ROWS: image_rows_reg <= cfg.data[DIM_W-1:0];
                    REG_IMAGE_COLS: image_cols_reg <= cfg.data[DIM_W-1:0];
                    REG_HALF_ROWS:  half_rows_reg  <= cfg.data[HALF_W-1:0];
                    REG_HALF_COLS:  half_cols_reg  <= cfg.data[HALF_W-1:0];
                    REG_MEAN_MODE:  mean_mode_reg  <= cfg.data[0];
                    default:        ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk counters, multiply and accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(pix_rd) * $signed(wt_rd);

        if (accept && is_compute)
        begin
            // Window origin sits half a window up and left of the centre
            base_r_reg <= $signed(POS_W'(req.row)) - $signed(POS_W'(hr));
            base_c_reg <= $signed(POS_W'(req.col)) - $signed(POS_W'(hc));
            wr_reg     <= '0;
            wc_reg     <= '0;
            acc_reg    <= '0;
            count_reg  <= '0;
            bad_reg    <= is_bad;
        end
        else
        begin
            if (state_reg == ST_WALK)
            begin
                if (wc_reg == win_c_last)
                begin
                    wc_reg <= '0;
                    wr_reg <= wr_reg + SPAN_W'(1);
                end
                else
                begin
                    wc_reg <= wc_reg + SPAN_W'(1);
                end
            end

            if (v0)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (v2_reg)
            begin
                acc_reg <= acc_reg + RES_W'(prod_reg);
            end
            else if ((state_reg == ST_DIV) && div_stat.done)
            begin
                acc_reg <= div_quo;
            end
        end

        if (out_load)
        begin
            out_result_reg <= acc_reg;
            out_count_reg  <= count_reg;
            out_bad_reg    <= bad_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result      = out_result_reg;
    assign rsp.cell_count  = out_count_reg;
    assign rsp.bad_request = out_bad_reg;
    assign cfg.ready       = 1'b1;

    `WFWF_ASSERT_NEXT(a_good_compute_walks, accept && is_compute && !is_bad, state_reg == ST_WALK, "in-range compute did not start the walk")
    `WFWF_ASSERT_NOW(a_bad_reports_zero, rsp.valid && rsp.bad_request, rsp.result == '0 && rsp.cell_count == '0, "bad request with nonzero result")
    `WFWF_ASSERT_NOW(a_div_nonzero, state_reg == ST_DIV, count_reg != '0, "divide by zero cell count")
    `WFWF_ASSERT_NOW(a_div_owned, div_stat.busy, state_reg == ST_DIV, "divider busy outside divide state")
endmodule

// ===== hdl/wfwf_ram.sv =====
`timescale 1ns / 1ps

module wfwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/wfwf_div.sv =====
`timescale 1ns / 1ps

// Signed by unsigned restoring divide, one quotient bit per cycle,
// truncating toward zero.
module wfwf_div
    import wfwf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  div_ctl_t                ctl,
    input  logic signed [RES_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output div_stat_t               stat,
    output logic signed [RES_W-1:0] quotient
);
    localparam int STEP_W = $clog2(RES_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [RES_W-1:0]  quo_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  dsr_reg;

    logic [CNT_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[RES_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(RES_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            neg_reg <= dividend[RES_W-1];
            quo_reg <= dividend[RES_W-1] ? -dividend : dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // Shift in one dividend bit, subtract when the divisor fits
            rem_reg <= fits ? CNT_W'(trial - {1'b0, dsr_reg}) : CNT_W'(trial);
            quo_reg <= {quo_reg[RES_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
endmodule
